@@ hw/rtl/dgwt_pkg.sv @@
// Shared constants and helpers for the depth-gated walk timer.
package dgwt_pkg;

  // Field widths fixed by the stream formats
  localparam int unsigned DEPTH_W   = 16;
  localparam int unsigned ELAPSED_W = 24;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned OUT_W     = 48;  // 44 field bits padded to whole bytes

  // Parameter defaults
  localparam int unsigned WINDOW_DEF     = 10;
  localparam int unsigned COUNT_BITS_DEF = 24;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  // Item kind carried on tuser
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_LO = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_HI = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_LO  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_HI  = 2'd3;

  // Band reset values in mm
  localparam logic [CFG_W-1:0] START_LO_RST = 16'd6500;
  localparam logic [CFG_W-1:0] START_HI_RST = 16'd6700;
  localparam logic [CFG_W-1:0] STOP_LO_RST  = 16'd1500;
  localparam logic [CFG_W-1:0] STOP_HI_RST  = 16'd1600;

  // Result word bit positions
  localparam int unsigned O_AVG_LSB     = 0;
  localparam int unsigned O_TIMING      = 16;
  localparam int unsigned O_STARTED     = 17;
  localparam int unsigned O_STOPPED     = 18;
  localparam int unsigned O_ELAPSED_LSB = 19;
  localparam int unsigned O_FINAL_VALID = 43;

  typedef struct packed {
    logic [DEPTH_W-1:0]   smoothed_depth_mm;
    logic                 timing;
    logic                 started;
    logic                 stopped;
    logic [ELAPSED_W-1:0] elapsed_ticks;
    logic                 final_valid;
  } result_t;

  function automatic logic [OUT_W-1:0] pack_result(input result_t r);
    logic [OUT_W-1:0] w;
    w = '0;
    w[O_AVG_LSB +: DEPTH_W]       = r.smoothed_depth_mm;
    w[O_TIMING]                   = r.timing;
    w[O_STARTED]                  = r.started;
    w[O_STOPPED]                  = r.stopped;
    w[O_ELAPSED_LSB +: ELAPSED_W] = r.elapsed_ticks;
    w[O_FINAL_VALID]              = r.final_valid;
    return w;
  endfunction

  function automatic logic in_band(input logic [DEPTH_W-1:0] v,
                                   input logic [CFG_W-1:0] lo,
                                   input logic [CFG_W-1:0] hi);
    return (v >= lo) && (v <= hi);
  endfunction

endpackage

@@ hw/rtl/depth_gated_walk_timer_core.sv @@
// Depth-gated walk timer: moving-average depth gate driving a tick stopwatch.
// Samples pass through read, accumulate and a serial divide of sum / fill count in the
//   one-bit-per-cycle restoring divider, then gate checks; a tick word goes straight to the checks.
// Throughput: one word at a time; s_axis_tready is low from accept until the result is
//   loaded into the output register, so no new word is taken before the last one is through.
// Reset (rst_ni low, async): bands to defaults, ring empty, counts zero, idle; ring not cleared.
module depth_gated_walk_timer_core #(
  parameter int unsigned WINDOW     = dgwt_pkg::WINDOW_DEF,     // 1..64 samples
  parameter int unsigned COUNT_BITS = dgwt_pkg::COUNT_BITS_DEF  // 8..32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [dgwt_pkg::DEPTH_W-1:0]    s_axis_tdata,  // [15:0] depth_mm
  input  logic                            s_axis_tuser,  // [0] cmd (0 sample, 1 tick)
  // Result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [15:0] smoothed_depth_mm, [16] timing, [17] started, [18] stopped,
  // [42:19] elapsed_ticks, [43] final_valid, [47:44] zero
  output logic [dgwt_pkg::OUT_W-1:0]      m_axis_tdata,
  // Configuration write port
  input  logic                            cfg_we_i,
  input  logic [dgwt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dgwt_pkg::CFG_W-1:0]      cfg_wdata_i
);

  localparam int unsigned DEPTH_W = dgwt_pkg::DEPTH_W;
  localparam int unsigned CFG_W   = dgwt_pkg::CFG_W;
  localparam int unsigned PTR_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned FILL_W  = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W   = DEPTH_W + FILL_W;
  localparam int unsigned DCNT_W  = $clog2(SUM_W + 1);
  localparam int unsigned SHOW_W  = (COUNT_BITS > dgwt_pkg::ELAPSED_W) ?
                                    COUNT_BITS : dgwt_pkg::ELAPSED_W;

  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(WINDOW - 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(WINDOW);

  // Sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;  // fetch the sample about to be evicted
  localparam logic [2:0] ST_ACC  = 3'd2;  // update sum, write ring
  localparam logic [2:0] ST_DIV  = 3'd3;  // serial divide sum / fill
  localparam logic [2:0] ST_FIN  = 3'd4;  // gate checks, load result word

  logic [2:0] state_q, state_d;

  // Band registers
  logic [CFG_W-1:0] start_lo_q, start_hi_q, stop_lo_q, stop_hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_lo_q <= dgwt_pkg::START_LO_RST;
      start_hi_q <= dgwt_pkg::START_HI_RST;
      stop_lo_q  <= dgwt_pkg::STOP_LO_RST;
      stop_hi_q  <= dgwt_pkg::STOP_HI_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dgwt_pkg::REG_START_LO: start_lo_q <= cfg_wdata_i;
        dgwt_pkg::REG_START_HI: start_hi_q <= cfg_wdata_i;
        dgwt_pkg::REG_STOP_LO:  stop_lo_q  <= cfg_wdata_i;
        dgwt_pkg::REG_STOP_HI:  stop_hi_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Datapath registers
  logic [PTR_W-1:0]   wptr_q;
  logic [FILL_W-1:0]  fill_q;
  logic [SUM_W-1:0]   sum_q;
  logic [DEPTH_W-1:0] avg_q;
  logic [DEPTH_W-1:0] depth_q;   // payload, no reset
  logic               kind_q;
  logic [SUM_W-1:0]   quo_q;     // dividend shifts out, quotient shifts in
  logic [FILL_W-1:0]  rem_q;     // below the fill count once the ring holds a sample
  logic [DCNT_W-1:0]  dcnt_q;
  logic               timing_q, final_seen_q;
  logic [COUNT_BITS-1:0] tick_q, final_q;
  logic               out_valid_q;
  logic [dgwt_pkg::OUT_W-1:0] out_data_q;

  // Ring store: one write port, one registered read port, no reset
  logic [DEPTH_W-1:0] ring_mem [WINDOW];
  logic [DEPTH_W-1:0] evict_q;
  logic               ring_we;

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[wptr_q] <= depth_q;
    end
    if (state_q == ST_RD) begin
      evict_q <= ring_mem[wptr_q];
    end
  end

  logic accept;
  logic out_free;
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign ring_we  = (state_q == ST_ACC);

  // Sum update: one subtract of the evicted sample (once the ring is full), one add
  logic             ring_full;
  logic [SUM_W-1:0] sum_new;
  assign ring_full = (fill_q == FILL_MAX);
  assign sum_new   = sum_q - (ring_full ? SUM_W'(evict_q) : '0) + SUM_W'(depth_q);

  // Restoring divider step
  logic [FILL_W:0] rem_sh;
  logic            q_bit;
  assign rem_sh = {rem_q, quo_q[SUM_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, fill_q});

  // Gate checks on the fresh average
  logic [DEPTH_W-1:0]   avg_new;
  logic                 is_sample, do_start, timing_mid, do_stop, timing_new;
  logic [COUNT_BITS-1:0] tick_new, final_new;
  logic [SHOW_W-1:0]    shown;
  dgwt_pkg::result_t    res;

  always_comb begin
    is_sample  = (kind_q == dgwt_pkg::CMD_SAMPLE);
    avg_new    = is_sample ? quo_q[DEPTH_W-1:0] : avg_q;
    do_start   = is_sample && !timing_q &&
                 dgwt_pkg::in_band(avg_new, start_lo_q, start_hi_q);
    timing_mid = timing_q || do_start;
    tick_new   = do_start ? '0 : tick_q;
    do_stop    = is_sample && timing_mid &&
                 dgwt_pkg::in_band(avg_new, stop_lo_q, stop_hi_q);
    timing_new = timing_mid && !do_stop;
    final_new  = do_stop ? tick_new : final_q;
    // tick while running: saturating increment
    if (!is_sample && timing_q && (tick_q != '1)) begin
      tick_new = tick_q + COUNT_BITS'(1);
    end
    shown = timing_new ? SHOW_W'(tick_new) : SHOW_W'(final_new);
    if (shown > SHOW_W'(dgwt_pkg::ELAPSED_MAX)) begin
      shown = SHOW_W'(dgwt_pkg::ELAPSED_MAX);
    end
    res.smoothed_depth_mm = avg_new;
    res.timing            = timing_new;
    res.started           = do_start;
    res.stopped           = do_stop;
    res.elapsed_ticks     = shown[dgwt_pkg::ELAPSED_W-1:0];
    res.final_valid       = final_seen_q || do_stop;
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (s_axis_tuser == dgwt_pkg::CMD_SAMPLE) ? ST_RD : ST_FIN;
        end
      end
      ST_RD:  state_d = ST_ACC;
      ST_ACC: state_d = ST_DIV;
      ST_DIV: begin
        if (dcnt_q == DCNT_W'(1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      wptr_q       <= '0;
      fill_q       <= '0;
      sum_q        <= '0;
      avg_q        <= '0;
      kind_q       <= dgwt_pkg::CMD_SAMPLE;
      rem_q        <= '0;
      dcnt_q       <= '0;
      timing_q     <= 1'b0;
      final_seen_q <= 1'b0;
      tick_q       <= '0;
      final_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      // a new word may replace the one leaving in the same cycle
      if ((state_q == ST_FIN) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            kind_q <= s_axis_tuser;
          end
        end
        ST_ACC: begin
          sum_q  <= sum_new;
          wptr_q <= (wptr_q == PTR_LAST) ? '0 : wptr_q + PTR_W'(1);
          if (!ring_full) begin
            fill_q <= fill_q + FILL_W'(1);
          end
          rem_q  <= '0;
          dcnt_q <= DCNT_W'(SUM_W);
        end
        ST_DIV: begin
          rem_q  <= q_bit ? FILL_W'(rem_sh - {1'b0, fill_q}) : rem_sh[FILL_W-1:0];
          dcnt_q <= dcnt_q - DCNT_W'(1);
        end
        ST_FIN: begin
          if (out_free) begin
            avg_q        <= avg_new;
            timing_q     <= timing_new;
            tick_q       <= tick_new;
            final_q      <= final_new;
            final_seen_q <= final_seen_q || do_stop;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      depth_q <= s_axis_tdata;
    end
    if (state_q == ST_ACC) begin
      quo_q <= sum_new;
    end else if (state_q == ST_DIV) begin
      quo_q <= {quo_q[SUM_W-2:0], q_bit};
    end
    if ((state_q == ST_FIN) && out_free) begin
      out_data_q <= dgwt_pkg::pack_result(res);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

@@ hw/rtl/dgwt_checker.sv @@
// Port-level checks for the depth-gated walk timer, bound to depth_gated_walk_timer_core.
module dgwt_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid,
  input logic                       s_axis_tready,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [dgwt_pkg::OUT_W-1:0] m_axis_tdata
);

  logic o_timing, o_started, o_stopped, o_final;
  logic [dgwt_pkg::ELAPSED_W-1:0] o_elapsed;
  assign o_timing  = m_axis_tdata[dgwt_pkg::O_TIMING];
  assign o_started = m_axis_tdata[dgwt_pkg::O_STARTED];
  assign o_stopped = m_axis_tdata[dgwt_pkg::O_STOPPED];
  assign o_final   = m_axis_tdata[dgwt_pkg::O_FINAL_VALID];
  assign o_elapsed = m_axis_tdata[dgwt_pkg::O_ELAPSED_LSB +: dgwt_pkg::ELAPSED_W];

  // A stop word leaves the watch idle and marks a completed run
  a_stop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && o_stopped |-> !o_timing && o_final)
    else $error("stop word shows timing or no final");

  // A start that did not also stop shows a fresh running count
  a_start_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && o_started && !o_stopped |-> o_timing && (o_elapsed == '0))
    else $error("start word not running from zero");

  // One word at a time: the input side is closed right after an accept
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("word accepted while busy");

  // Stalled result word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result word changed");

endmodule

bind depth_gated_walk_timer_core dgwt_checker u_dgwt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
